// ===== rtl/itoa_pkg.sv =====
`default_nettype none

package itoa_pkg;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;
  localparam logic [3:0] BCD_FIVE    = 4'd5;
  localparam logic [3:0] BCD_THREE   = 4'd3;
  localparam int         STEP_BITS   = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic conv;
    logic skip;
    logic emit_sign;
    logic emit_digit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic top_zero;
    logic one_left;
    logic negative;
    logic out_free;
  } ctrl_stat_t;

endpackage

`default_nettype wire

// ===== rtl/itoa_dp.sv =====
`default_nettype none

module itoa_dp #(
  parameter int VALUE_BITS = 64
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire [63:0]              value,
  input  itoa_pkg::ctrl_cmd_t     cmd,
  output itoa_pkg::ctrl_stat_t    stat,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic [7:0]              out_char,
  output logic                    out_last
);

  localparam int NSTEPS = (VALUE_BITS + itoa_pkg::STEP_BITS - 1) / itoa_pkg::STEP_BITS;
  localparam int PAD    = NSTEPS * itoa_pkg::STEP_BITS;
  localparam int NDIG   = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int BW     = NDIG * 4;
  localparam int SW     = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;
  localparam int DW     = $clog2(NDIG + 1);

  logic [PAD-1:0]        mag;
  logic [BW-1:0]         bcd;
  logic [SW-1:0]         step;
  logic [DW-1:0]         digits_left;
  logic                  negative;
  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag_in;
  logic [BW-1:0]         bcd_next;
  logic [PAD-1:0]        mag_next;

  assign raw    = value[VALUE_BITS-1:0];
  assign mag_in = raw[VALUE_BITS-1] ? (~raw + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : raw;

  always_comb begin
    bcd_next = bcd;
    mag_next = mag;
    for (int s = 0; s < itoa_pkg::STEP_BITS; s++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (bcd_next[d*4 +: 4] >= itoa_pkg::BCD_FIVE) begin
          bcd_next[d*4 +: 4] = bcd_next[d*4 +: 4] + itoa_pkg::BCD_THREE;
        end
      end
      bcd_next = {bcd_next[BW-2:0], mag_next[PAD-1]};
      mag_next = {mag_next[PAD-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag         <= PAD'(mag_in);
      negative    <= raw[VALUE_BITS-1];
      bcd         <= '0;
      step        <= '0;
      digits_left <= DW'(NDIG);
    end else if (cmd.conv) begin
      mag  <= mag_next;
      bcd  <= bcd_next;
      step <= step + 1'b1;
    end else if (cmd.skip || cmd.emit_digit) begin
      bcd         <= {bcd[BW-5:0], 4'b0000};
      digits_left <= digits_left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_char <= itoa_pkg::ASCII_MINUS;
      out_last <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char <= itoa_pkg::ASCII_ZERO + {4'b0000, bcd[BW-1 -: 4]};
      out_last <= (digits_left == DW'(1));
    end
  end

  assign stat.conv_done = (step == SW'(NSTEPS - 1));
  assign stat.top_zero  = (bcd[BW-1 -: 4] == 4'd0);
  assign stat.one_left  = (digits_left == DW'(1));
  assign stat.negative  = negative;
  assign stat.out_free  = !out_valid || out_ready;

endmodule

`default_nettype wire

// ===== rtl/itoa_ctrl.sv =====
`default_nettype none

module itoa_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  itoa_pkg::ctrl_stat_t  stat,
  output itoa_pkg::ctrl_cmd_t   cmd
);

  itoa_pkg::state_t state;
  itoa_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itoa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      itoa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = itoa_pkg::ST_CONV;
        end
      end
      itoa_pkg::ST_CONV: begin
        cmd.conv = 1'b1;
        if (stat.conv_done) begin
          state_next = itoa_pkg::ST_SKIP;
        end
      end
      itoa_pkg::ST_SKIP: begin
        if (stat.top_zero && !stat.one_left) begin
          cmd.skip = 1'b1;
        end else if (stat.negative) begin
          state_next = itoa_pkg::ST_SIGN;
        end else begin
          state_next = itoa_pkg::ST_EMIT;
        end
      end
      itoa_pkg::ST_SIGN: begin
        if (stat.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = itoa_pkg::ST_EMIT;
        end
      end
      itoa_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_digit = 1'b1;
          if (stat.one_left) begin
            state_next = itoa_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = itoa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/signed_int_to_decimal_ascii_top.sv =====
// Conversion: an accepted word is converted four magnitude bits per cycle through the
// BCD adjust network; leading zero digits are then dropped at one per cycle before the
// first character appears. A negative number gets a minus sign before its digits.
// Flow: a new number is accepted only once the last character of the previous one has
// been issued; output back-pressure stalls the characters. NDIG = 19 at 64 bits.
// Reset: synchronous on rst; the controller returns to idle and the output word is dropped.
`default_nettype none

module signed_int_to_decimal_ascii_top #(
  parameter int VALUE_BITS = 64
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire [63:0]  s_axis_tdata,   // value[63:0]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // character[7:0]
  output logic        m_axis_tlast
);

  itoa_pkg::ctrl_cmd_t  cmd;
  itoa_pkg::ctrl_stat_t stat;

  itoa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  itoa_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .value     (s_axis_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_char  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== rtl/itoa_chk.sv =====
`default_nettype none

module itoa_chk (
  input wire        clk,
  input wire        rst,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [7:0]  m_axis_tdata,
  input wire        m_axis_tlast
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output word valid after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready again straight after an accepted word");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output word changed");

  a_char_set: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata == itoa_pkg::ASCII_MINUS ||
      (m_axis_tdata >= itoa_pkg::ASCII_ZERO &&
       m_axis_tdata <= itoa_pkg::ASCII_ZERO + 8'd9))
    else $error("output character is neither a digit nor a minus sign");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata == itoa_pkg::ASCII_MINUS |-> !m_axis_tlast)
    else $error("minus sign marked as the final character");

endmodule

bind signed_int_to_decimal_ascii_top itoa_chk u_itoa_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;

  typedef struct {
    logic [7:0] character;
    logic       last;
  } text_char_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  text_char_t  expected_text[$];
  int          fail_count = 0;
  bit          sender_eager = 1'b0;

  signed_int_to_decimal_ascii_top DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Queues the decimal text of one accepted word, sign first, digits most significant first.
  function automatic void predict_text(input logic [63:0] value);
    logic [63:0] magnitude;
    logic [7:0]  digits[20];
    int          ndigits;
    text_char_t  entry;
    magnitude = value[63] ? (~value + 64'd1) : value;
    ndigits = 0;
    do begin
      digits[ndigits] = itoa_pkg::ASCII_ZERO + 8'(magnitude % 64'd10);
      ndigits++;
      magnitude = magnitude / 64'd10;
    end while (magnitude != 0 && ndigits < 19);
    if (value[63]) begin
      entry.character = itoa_pkg::ASCII_MINUS;
      entry.last = 1'b0;
      expected_text.push_back(entry);
    end
    for (int i = ndigits - 1; i >= 0; i--) begin
      entry.character = digits[i];
      entry.last = (i == 0);
      expected_text.push_back(entry);
    end
  endfunction

  task automatic send_value(input logic [63:0] value);
    int gap;
    gap = sender_eager ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk); while (!s_axis_tready);
    predict_text(value);
  endtask

  task automatic test_extremes();
    logic [63:0] corner[$];
    corner = '{64'd0, 64'd1, -64'd1, 64'd9, 64'd10, -64'd9, -64'd10, 64'd99, 64'd100,
               -64'd100, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
               64'h8000_0000_0000_0001, 64'd1000000000000000000,
               64'd999999999999999999, -64'd1000000000000000000,
               64'd4294967295, -64'd2147483648, 64'd1234567890123456789,
               64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'hFFFF_FFFF_0000_0000};
    foreach (corner[i]) send_value(corner[i]);
  endtask

  task automatic test_random(input int count);
    logic [63:0] raw;
    logic [63:0] limit;
    logic [63:0] value;
    int          ndigits;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) sender_eager = ($urandom_range(0, 3) == 0);
      raw = {$urandom, $urandom};
      if ($urandom_range(0, 4) == 0) begin
        value = raw;
      end else begin
        ndigits = $urandom_range(1, 18);
        limit = 64'd1;
        repeat (ndigits) limit = limit * 64'd10;
        value = raw % limit;
        if ($urandom_range(0, 1) == 1) value = ~value + 64'd1;
      end
      send_value(value);
    end
  endtask

  // The receiver stalls a random number of cycles before each word, with eager stretches.
  initial begin : drain_characters
    int  stall;
    int  words;
    bit  eager;
    words = 0;
    eager = 1'b0;
    forever begin
      if (words % 30 == 0) eager = ($urandom_range(0, 3) == 0);
      stall = eager ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && !rst));
      words++;
    end
  end

  always @(posedge clk) begin : check_characters
    text_char_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_text.size() == 0) begin
        $error("unexpected word: character %0d last %0b", m_axis_tdata, m_axis_tlast);
        fail_count++;
      end else begin
        want = expected_text.pop_front();
        if (m_axis_tdata !== want.character) begin
          $error("character: expected %0d, got %0d", want.character, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_random(390);
    s_axis_tvalid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (fail_count == 0 && expected_text.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/itoa_pkg.sv
rtl/itoa_dp.sv
rtl/itoa_ctrl.sv
rtl/signed_int_to_decimal_ascii_top.sv
rtl/itoa_chk.sv
dv/tb.sv
